### hdl/fba_pkg.sv
// Shared types and constants for the fixed-size block free-list allocator.
package fba_pkg;

   // Field widths of the request and response items
   localparam int unsigned IDX_W    = 4;
   localparam int unsigned BYTES_W  = 13;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 5;

   // Packed stream widths (whole bytes)
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 32;

   // Block size after reset
   localparam logic [BYTES_W-1:0] ENTRY_BYTES_RESET = 13'd4;

   // Request kind carried in req_tuser
   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_RANGE  = 3'd2,
      ST_DOUBLE = 3'd3,
      ST_SIZE   = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

### hdl/fba_link_ram.sv
// Link store: simple dual-port RAM, one write and one registered read per cycle.
module fba_link_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4,
   parameter int unsigned WIDTH = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fixed_block_free_list_allocator.sv
// Top level of the fixed-size block pool allocator with a LIFO free list.
//
// Requests arrive on the req_ stream: req_tuser selects allocate (0) or free (1),
// req_tdata carries the block index to free and the requested size. Each request
// produces exactly one transfer on the rsp_ stream with the granted index, its byte
// offset, in rsp_tuser a status code, and the in-use count after the request.
// Users write the block size via csr_wr_en / csr_wr_data only while idle; it is not enforced.
//
// Timing: a request is accepted in the idle state; the next cycle the link store
// returns the word of the addressed block (the free-list head on allocate, the
// given block on free), and the response is loaded into the output register at that
// edge. A request thus passes through the link store's read register and then the
// output register, and no new request is accepted until its response is registered.
// The output register holds a response while rsp_tready is low; a new request is
// accepted as soon as that response is taken, in the same cycle.
// Reset puts every block on the free list in order 0..ENTRIES-1 with none allocated.
// No clearing pass is needed: blocks at or above a fresh counter were never handed
// out and are read as "free, linked to the next index" without touching the RAM.
module fixed_block_free_list_allocator
   import fba_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] block_index, [16:4] request_bytes
   input  logic                  req_tuser,  // [0] mode
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] granted_index, [19:4] byte_offset,
                                             // [24:20] in_use_count
   output logic [STATUS_W-1:0]   rsp_tuser,  // [2:0] status
   // configuration
   input  logic                  csr_wr_en,
   input  logic [BYTES_W-1:0]    csr_wr_data
);

   localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned LW  = $clog2(ENTRIES + 1);
   localparam int unsigned MW  = LW + 1;
   localparam int unsigned PW  = (AW + BYTES_W > OFFSET_W) ? AW + BYTES_W : OFFSET_W;
   localparam logic [LW-1:0] LINK_ONE = LW'(1);

   // registers
   state_type            state_ff, state_in;
   logic [LW-1:0]        head_ff, head_in;
   logic [LW-1:0]        fresh_ff, fresh_in;
   logic [LW-1:0]        used_ff, used_in;
   logic [BYTES_W-1:0]   entry_bytes_ff;
   mode_type             mode_ff;
   logic [IDX_W-1:0]     bidx_ff;
   logic [BYTES_W-1:0]   req_bytes_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // link store ports
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [MW-1:0]        wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [MW-1:0]        rd_data;

   // decoded request fields
   mode_type             req_mode;
   logic [IDX_W-1:0]     req_bidx;
   logic [BYTES_W-1:0]   req_bytes;
   logic                 req_fire;

   // execute-stage helpers
   logic [31:0]          req_bidx_w;
   logic [31:0]          bidx_w;
   logic [31:0]          head_w;
   logic [31:0]          fresh_w;
   logic [AW-1:0]        head_addr;
   logic [AW-1:0]        bidx_addr;
   logic                 head_fresh;
   logic                 blk_alloc;
   logic [PW-1:0]        product;

   assign req_mode  = mode_type'(req_tuser);
   assign req_bidx  = req_tdata[IDX_W-1:0];
   assign req_bytes = req_tdata[IDX_W+BYTES_W-1:IDX_W];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign req_bidx_w = 32'(req_bidx);
   assign bidx_w     = 32'(bidx_ff);
   assign head_w     = 32'(head_ff);
   assign fresh_w    = 32'(fresh_ff);
   assign head_addr  = head_ff[AW-1:0];
   assign bidx_addr  = bidx_w[AW-1:0];

   // read the addressed block's word on acceptance
   assign rd_en   = req_fire;
   assign rd_addr = (req_mode == MODE_FREE) ? req_bidx_w[AW-1:0] : head_addr;

   fba_link_ram #(
      .DEPTH (ENTRIES),
      .AW    (AW),
      .WIDTH (MW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // untouched blocks sit at or above the fresh counter
   assign head_fresh = (head_ff == fresh_ff);
   assign blk_alloc  = (bidx_w < fresh_w) && rd_data[LW];
   assign product    = PW'(head_addr) * PW'(entry_bytes_ff);

   // next state, list update and response
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fresh_in      = fresh_ff;
      used_in       = used_ff;
      wr_en         = 1'b0;
      wr_addr       = head_addr;
      wr_data       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_index_in  = '0;
            rsp_offset_in = '0;
            rsp_status_in = ST_OK;
            if (mode_ff == MODE_ALLOC) begin
               if (req_bytes_ff != entry_bytes_ff) begin
                  rsp_status_in = ST_SIZE;
               end else if (head_w >= ENTRIES) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  // pop the head, mark it allocated
                  wr_en   = 1'b1;
                  wr_addr = head_addr;
                  wr_data = {1'b1, {LW{1'b0}}};
                  if (head_fresh) begin
                     head_in  = head_ff + LINK_ONE;
                     fresh_in = fresh_ff + LINK_ONE;
                  end else begin
                     head_in = rd_data[LW-1:0];
                  end
                  used_in       = used_ff + LINK_ONE;
                  rsp_index_in  = head_w[IDX_W-1:0];
                  rsp_offset_in = product[OFFSET_W-1:0];
               end
            end else begin
               if (bidx_w >= ENTRIES) begin
                  rsp_status_in = ST_RANGE;
               end else if (!blk_alloc) begin
                  rsp_status_in = ST_DOUBLE;
               end else begin
                  // push the block, link it to the old head
                  wr_en   = 1'b1;
                  wr_addr = bidx_addr;
                  wr_data = {1'b0, head_ff};
                  head_in = LW'(bidx_w);
                  used_in = used_ff - LINK_ONE;
               end
            end
            rsp_count_in = COUNT_W'(used_in);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         fresh_ff       <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         entry_bytes_ff <= ENTRY_BYTES_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entry_bytes_ff <= csr_wr_data;
         end
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff      <= req_mode;
         bidx_ff      <= req_bidx;
         req_bytes_ff <= req_bytes;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_offset_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule
